// ===== hw/rtl/h2fc_pkg.sv =====
// ----------------------------------------------------------------------------
// h2fc_pkg
// Shared types and constants of the HTTP/2 receive flow-control unit.
// ----------------------------------------------------------------------------
package h2fc_pkg;

  localparam int unsigned MaxDataChunkDefault = 16384;

  localparam logic [7:0] FT_DATA     = 8'd0;
  localparam logic [7:0] FT_HEADERS  = 8'd1;
  localparam logic [7:0] FT_RST      = 8'd3;
  localparam logic [7:0] FT_SETTINGS = 8'd4;
  localparam logic [7:0] FT_PING     = 8'd6;
  localparam logic [7:0] FT_GOAWAY   = 8'd7;
  localparam logic [7:0] FT_WINUPD   = 8'd8;

  localparam logic [7:0] FL_END    = 8'h01;
  localparam logic [7:0] FL_ACK    = 8'h01;
  localparam logic [7:0] FL_PADDED = 8'h08;

  localparam logic [15:0] SET_ID_WINDOW = 16'h0004;
  localparam logic [16:0] WIN_REFILL    = 17'd65535;
  localparam logic [16:0] WIN_LOW       = 17'd16000;
  localparam logic [15:0] PKT_BODY_MAX  = 16'd32768;
  localparam logic [3:0]  HDR_BYTES     = 4'd9;

  localparam logic [1:0] REG_DOWN_ID = 2'd0;
  localparam logic [1:0] REG_UP_ID   = 2'd1;
  localparam logic [1:0] REG_PKT     = 2'd2;

  typedef enum logic [2:0] {
    K_DATA    = 3'd0,
    K_SET_ACK = 3'd1,
    K_PING    = 3'd2,
    K_WINUPD  = 3'd3,
    K_END     = 3'd4,
    K_CLOSED  = 3'd5,
    K_GRANT   = 3'd6,
    K_ERROR   = 3'd7
  } kind_t;

  typedef enum logic [2:0] {
    LS_BOOT = 3'b001,
    LS_OPEN = 3'b010,
    LS_FAIL = 3'b100
  } link_t;

  typedef struct packed {
    logic        cmd;
    logic [7:0]  rx_byte;
    logic [15:0] want_len;
  } in_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  data_byte;
    logic [63:0] ping_data;
    logic [30:0] update_stream;
    logic [15:0] grant_len;
    logic        last;
  } res_t;

endpackage

// ===== hw/rtl/h2fc_outq.sv =====
// ----------------------------------------------------------------------------
// h2fc_outq
// Holds the up to four results of one transaction and hands them out in order.
// ----------------------------------------------------------------------------
module h2fc_outq (
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  logic [2:0]         load_cnt,
  input  h2fc_pkg::res_t     load_items [4],
  output logic               room,
  output logic               out_valid,
  input  logic               out_stall,
  output h2fc_pkg::res_t     out_data
);
  import h2fc_pkg::*;

  res_t       items [4];
  logic [2:0] cnt;
  logic       pop;

  assign pop       = out_valid && !out_stall;
  assign out_valid = (cnt != 3'd0);
  assign out_data  = items[0];
  assign room      = (cnt == 3'd0) || (cnt == 3'd1 && pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 3'd0;
    end else if (load) begin
      cnt <= load_cnt;
    end else if (pop) begin
      cnt <= cnt - 3'd1;
    end
  end

  // advance the entries on a pop, replace them on a load
  always_ff @(posedge clk) begin
    if (load) begin
      items <= load_items;
    end else if (pop) begin
      items[0] <= items[1];
      items[1] <= items[2];
      items[2] <= items[3];
    end
  end

endmodule

// ===== hw/rtl/http2_frame_rx_flow_control_unit.sv =====
// ----------------------------------------------------------------------------
// http2_frame_rx_flow_control_unit
// HTTP/2 frame deframer with send/receive window bookkeeping and write grants.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  in      | input     | in_valid/in_stall  | h2fc_pkg::in_t  (cmd, rx_byte, want_len)
//  out     | output    | out_valid/out_stall| h2fc_pkg::res_t (kind .. last)
//  cfg     | input     | cfg_we             | cfg_index, cfg_data
//
//  One transaction is taken per cycle while the output queue has room; all of
//  its work is done in the accept cycle and its 0 to 4 results land in a small
//  output queue. The queue drains one result per cycle while out is not stalled;
//  the next transaction enters as the last result of the one before leaves.
//  Reset (rst, synchronous) returns the parser, windows and link to boot.
//  A stall on out holds the queue and raises in_stall once it is not about to empty.
// ----------------------------------------------------------------------------
module http2_frame_rx_flow_control_unit #(
  parameter int unsigned MAX_DATA_CHUNK = h2fc_pkg::MaxDataChunkDefault
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  h2fc_pkg::in_t   in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output h2fc_pkg::res_t  out_data,
  input  logic            cfg_we,
  input  logic [1:0]      cfg_index,
  input  logic [30:0]     cfg_data
);
  import h2fc_pkg::*;

  localparam logic [31:0] ChunkMax = 32'(MAX_DATA_CHUNK);

  // configuration
  logic [30:0] down_id, up_id;
  logic        pkt_mode;

  // parser and window state
  logic [3:0]  hidx, hidx_next;
  logic [23:0] flen, flen_next;
  logic [7:0]  ftype, ftype_next;
  logic [7:0]  fflags, fflags_next;
  logic [30:0] fstream, fstream_next;
  logic [23:0] pcount, pcount_next;
  logic [2:0]  sub6, sub6_next;
  logic [7:0]  padlen, padlen_next;
  logic [63:0] fshift, fshift_next;
  link_t       link, link_next;
  logic [31:0] conn_send, conn_send_next, up_send, up_send_next;
  logic [16:0] conn_recv, conn_recv_next, down_recv, down_recv_next;
  logic        stream_fin, stream_fin_next;

  logic       accept, room;
  res_t       cand [4];
  logic [3:0] cv;
  res_t       items [4];
  logic [2:0] nres;

  assign in_stall = !room;
  assign accept   = in_valid && room;

  always_ff @(posedge clk) begin
    if (rst) begin
      down_id  <= 31'd1;
      up_id    <= 31'd1;
      pkt_mode <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DOWN_ID: down_id  <= cfg_data;
        REG_UP_ID:   up_id    <= cfg_data;
        REG_PKT:     pkt_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // next-state and result logic for one transaction
  always_comb begin
    logic        done;
    logic        dn;
    logic [31:0] g;
    logic [30:0] inc;
    logic [23:0] dlen;
    logic [2:0]  pos;
    res_t        zr;

    zr = '0;
    for (int k = 0; k < 4; k++) cand[k] = zr;
    cv = '0;
    done = 1'b0;
    dn = 1'b0;
    g = '0;
    inc = '0;
    dlen = '0;
    pos = '0;

    hidx_next = hidx;       flen_next = flen;       ftype_next = ftype;
    fflags_next = fflags;   fstream_next = fstream; pcount_next = pcount;
    sub6_next = sub6;       padlen_next = padlen;   fshift_next = fshift;
    link_next = link;       conn_send_next = conn_send; up_send_next = up_send;
    conn_recv_next = conn_recv; down_recv_next = down_recv; stream_fin_next = stream_fin;

    if (link == LS_FAIL) begin
      cand[0].kind = K_ERROR;
      cv[0] = 1'b1;
    end else if (in_data.cmd) begin
      cand[0].kind = K_GRANT;
      cv[0] = 1'b1;
      if (link == LS_OPEN && in_data.want_len != 16'd0) begin
        if (pkt_mode) begin
          g = (in_data.want_len < PKT_BODY_MAX) ? {16'd0, in_data.want_len}
                                                : {16'd0, PKT_BODY_MAX};
        end else begin
          g = {16'd0, in_data.want_len};
          if (conn_send < g) g = conn_send;
          if (up_send < g) g = up_send;
          if (g > ChunkMax) g = ChunkMax;
          conn_send_next = conn_send - g;
          up_send_next   = up_send - g;
        end
      end
      cand[0].grant_len = g[15:0];
    end else if (hidx < HDR_BYTES) begin
      // collect the 9-byte frame header
      if (hidx < 4'd3) flen_next = {flen[15:0], in_data.rx_byte};
      else if (hidx == 4'd3) ftype_next = in_data.rx_byte;
      else if (hidx == 4'd4) fflags_next = in_data.rx_byte;
      else fstream_next = {fstream[22:0], in_data.rx_byte};
      hidx_next = hidx + 4'd1;
      if (hidx_next == HDR_BYTES) begin
        pcount_next = '0;
        sub6_next   = '0;
        fshift_next = '0;
        padlen_next = '0;
        if (flen_next == 24'd0) begin
          done = 1'b1;
          hidx_next = '0;
        end
      end
    end else begin
      // payload byte
      fshift_next = {fshift[55:0], in_data.rx_byte};
      if (ftype == FT_SETTINGS && (fflags & FL_ACK) == 8'd0 && sub6 == 3'd5 &&
          fshift_next[47:32] == SET_ID_WINDOW) begin
        conn_send_next = fshift_next[31:0];
        up_send_next   = fshift_next[31:0];
      end
      if (ftype == FT_DATA && fstream == down_id) begin
        if ((fflags & FL_PADDED) != 8'd0) begin
          if (pcount == 24'd0) begin
            padlen_next = in_data.rx_byte;
          end else if ({1'b0, pcount} + 25'(padlen) < {1'b0, flen}) begin
            cand[0].kind = K_DATA;
            cand[0].data_byte = in_data.rx_byte;
            cv[0] = 1'b1;
          end
        end else begin
          cand[0].kind = K_DATA;
          cand[0].data_byte = in_data.rx_byte;
          cv[0] = 1'b1;
        end
      end else if (ftype == FT_DATA && (fflags & FL_PADDED) != 8'd0 &&
                   pcount == 24'd0) begin
        padlen_next = in_data.rx_byte;
      end
      if ({1'b0, pcount} + 25'd1 >= {1'b0, flen}) begin
        done = 1'b1;
        hidx_next = '0;
      end else begin
        pcount_next = pcount + 24'd1;
        sub6_next = (sub6 == 3'd5) ? 3'd0 : sub6 + 3'd1;
      end
    end

    // end of frame: act on the completed frame
    if (done) begin
      dn = (fstream_next == down_id);
      case (ftype_next)
        FT_SETTINGS: begin
          if ((fflags_next & FL_ACK) == 8'd0) begin
            cand[1].kind = K_SET_ACK;
            cv[1] = 1'b1;
          end
          if (link == LS_BOOT) link_next = LS_OPEN;
        end
        FT_WINUPD: begin
          if (flen_next == 24'd4) begin
            inc = fshift_next[30:0];
            if (fstream_next == 31'd0) conn_send_next = conn_send_next + {1'b0, inc};
            else if (fstream_next == up_id) up_send_next = up_send_next + {1'b0, inc};
          end
        end
        FT_PING: begin
          if (flen_next == 24'd8 && (fflags_next & FL_ACK) == 8'd0) begin
            cand[1].kind = K_PING;
            cand[1].ping_data = fshift_next;
            cv[1] = 1'b1;
          end
        end
        FT_GOAWAY, FT_RST: begin
          link_next = LS_FAIL;
          cand[1].kind = K_CLOSED;
          cv[1] = 1'b1;
        end
        FT_HEADERS: begin
          if ((fflags_next & FL_END) != 8'd0 && dn) begin
            stream_fin_next = 1'b1;
            cand[1].kind = K_END;
            cv[1] = 1'b1;
          end
        end
        FT_DATA: begin
          if ((fflags_next & FL_PADDED) != 8'd0 &&
              (flen_next == 24'd0 || {16'd0, padlen_next} > flen_next - 24'd1)) begin
            cand[1].kind = K_ERROR;
            cv[1] = 1'b1;
          end else begin
            dlen = ((fflags_next & FL_PADDED) != 8'd0)
                 ? flen_next - 24'd1 - {16'd0, padlen_next} : flen_next;
            if (dn && dlen != 24'd0) begin
              conn_recv_next = ({7'd0, conn_recv} > dlen) ? conn_recv - dlen[16:0] : '0;
              down_recv_next = ({7'd0, down_recv} > dlen) ? down_recv - dlen[16:0] : '0;
              if (conn_recv_next < WIN_LOW) begin
                cand[1].kind = K_WINUPD;
                cv[1] = 1'b1;
                conn_recv_next = conn_recv_next + WIN_REFILL;
              end
              if (down_recv_next < WIN_LOW) begin
                cand[2].kind = K_WINUPD;
                cand[2].update_stream = down_id;
                cv[2] = 1'b1;
                down_recv_next = down_recv_next + WIN_REFILL;
              end
            end
            if ((fflags_next & FL_END) != 8'd0 && dn) begin
              stream_fin_next = 1'b1;
              cand[3].kind = K_END;
              cv[3] = 1'b1;
            end
          end
        end
        default: ;
      endcase
    end

    // pack the present results to the front and mark the final one
    for (int k = 0; k < 4; k++) items[k] = zr;
    for (int k = 0; k < 4; k++) begin
      if (cv[k]) begin
        items[pos[1:0]] = cand[k];
        pos = pos + 3'd1;
      end
    end
    if (pos != 3'd0) items[2'(pos - 3'd1)].last = 1'b1;
    nres = pos;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hidx <= '0; flen <= '0; ftype <= '0; fflags <= '0; fstream <= '0;
      pcount <= '0; sub6 <= '0; padlen <= '0; fshift <= '0;
      link <= LS_BOOT;
      conn_send <= 32'd65535; up_send <= 32'd65535;
      conn_recv <= WIN_REFILL; down_recv <= WIN_REFILL;
      stream_fin <= 1'b0;
    end else if (accept) begin
      hidx <= hidx_next; flen <= flen_next; ftype <= ftype_next;
      fflags <= fflags_next; fstream <= fstream_next; pcount <= pcount_next;
      sub6 <= sub6_next; padlen <= padlen_next; fshift <= fshift_next;
      link <= link_next;
      conn_send <= conn_send_next; up_send <= up_send_next;
      conn_recv <= conn_recv_next; down_recv <= down_recv_next;
      stream_fin <= stream_fin_next;
    end
  end

  h2fc_outq u_outq (
    .clk        (clk),
    .rst        (rst),
    .load       (accept),
    .load_cnt   (nres),
    .load_items (items),
    .room       (room),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule

// ===== tb/h2fc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// h2fc_checker
// Watches the input, output and register ports of the flow-control unit,
// predicts every result from its own copy of the parser and window state,
// and compares each output transaction with the oldest prediction.
// ----------------------------------------------------------------------------
module h2fc_checker
  import h2fc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  in_t         in_data,
  input  logic        out_valid,
  input  logic        out_stall,
  input  res_t        out_data,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [30:0] cfg_data,
  output int          mismatches,
  output int          results_due
);

  localparam int unsigned ChunkLimit = MaxDataChunkDefault;

  // register copies
  logic [30:0] down_id, up_id;
  logic        pkt_mode;

  // parser and window copies
  logic [3:0]  hdr_pos;
  logic [23:0] frm_len, pay_pos;
  logic [7:0]  frm_type, frm_flags, pad_len;
  logic [30:0] frm_sid;
  logic [63:0] shift_reg;
  link_t       link;
  logic [31:0] conn_tx_win, up_tx_win, conn_rx_win, down_rx_win;
  logic        peer_done;

  res_t step_res[4];
  int   step_cnt;
  res_t results_q[$];

  task automatic emit(kind_t k, logic [7:0] d, logic [63:0] p, logic [30:0] s,
                      logic [15:0] g);
    if (step_cnt < 4) begin
      step_res[step_cnt] = '{kind: k, data_byte: d, ping_data: p, update_stream: s,
                             grant_len: g, last: 1'b0};
      step_cnt++;
    end
  endtask

  task automatic close_frame();
    logic        on_down;
    logic [31:0] dlen;
    logic        bad_pad;
    on_down = (frm_sid == down_id);
    bad_pad = 1'b0;
    case (frm_type)
      FT_SETTINGS: begin
        if ((frm_flags & FL_ACK) == 0) emit(K_SET_ACK, 0, 0, 0, 0);
        if (link == LS_BOOT) link = LS_OPEN;
      end
      FT_WINUPD: begin
        if (frm_len == 24'd4) begin
          if (frm_sid == 0) conn_tx_win += {1'b0, shift_reg[30:0]};
          else if (frm_sid == up_id) up_tx_win += {1'b0, shift_reg[30:0]};
        end
      end
      FT_PING: begin
        if (frm_len == 24'd8 && (frm_flags & FL_ACK) == 0)
          emit(K_PING, 0, shift_reg, 0, 0);
      end
      FT_GOAWAY, FT_RST: begin
        link = LS_FAIL;
        emit(K_CLOSED, 0, 0, 0, 0);
      end
      FT_HEADERS: begin
        if ((frm_flags & FL_END) != 0 && on_down) begin
          peer_done = 1'b1;
          emit(K_END, 0, 0, 0, 0);
        end
      end
      FT_DATA: begin
        dlen = {8'd0, frm_len};
        if ((frm_flags & FL_PADDED) != 0) begin
          if (frm_len == 0 || {24'd0, pad_len} > {8'd0, frm_len} - 32'd1) bad_pad = 1'b1;
          else dlen = {8'd0, frm_len} - 32'd1 - {24'd0, pad_len};
        end
        if (bad_pad) begin
          emit(K_ERROR, 0, 0, 0, 0);
        end else begin
          if (on_down && dlen > 0) begin
            conn_rx_win = (conn_rx_win > dlen) ? conn_rx_win - dlen : 32'd0;
            down_rx_win = (down_rx_win > dlen) ? down_rx_win - dlen : 32'd0;
            if (conn_rx_win < {15'd0, WIN_LOW}) begin
              emit(K_WINUPD, 0, 0, 0, 0);
              conn_rx_win += {15'd0, WIN_REFILL};
            end
            if (down_rx_win < {15'd0, WIN_LOW}) begin
              emit(K_WINUPD, 0, 0, down_id, 0);
              down_rx_win += {15'd0, WIN_REFILL};
            end
          end
          if ((frm_flags & FL_END) != 0 && on_down) begin
            peer_done = 1'b1;
            emit(K_END, 0, 0, 0, 0);
          end
        end
      end
      default: ;
    endcase
  endtask

  task automatic take_byte(logic [7:0] b);
    int unsigned pos;
    if (hdr_pos < HDR_BYTES) begin
      if (hdr_pos < 3) frm_len = {frm_len[15:0], b};
      else if (hdr_pos == 3) frm_type = b;
      else if (hdr_pos == 4) frm_flags = b;
      else frm_sid = {frm_sid[22:0], b};
      hdr_pos++;
      if (hdr_pos == HDR_BYTES) begin
        pay_pos = '0;
        shift_reg = '0;
        pad_len = '0;
        if (frm_len == 0) begin
          close_frame();
          hdr_pos = '0;
        end
      end
    end else begin
      shift_reg = {shift_reg[55:0], b};
      pos = 32'(pay_pos);
      // a complete settings entry takes effect on its last byte
      if (frm_type == FT_SETTINGS && (frm_flags & FL_ACK) == 0 && pos % 6 == 5 &&
          shift_reg[47:32] == SET_ID_WINDOW) begin
        conn_tx_win = shift_reg[31:0];
        up_tx_win = shift_reg[31:0];
      end
      if (frm_type == FT_DATA && frm_sid == down_id) begin
        if ((frm_flags & FL_PADDED) != 0) begin
          if (pos == 0) pad_len = b;
          else if (pos + pad_len < frm_len) emit(K_DATA, b, 0, 0, 0);
        end else begin
          emit(K_DATA, b, 0, 0, 0);
        end
      end else if (frm_type == FT_DATA && (frm_flags & FL_PADDED) != 0 && pos == 0) begin
        pad_len = b;
      end
      if (pos + 1 >= frm_len) begin
        close_frame();
        hdr_pos = '0;
      end else begin
        pay_pos = 24'(pos + 1);
      end
    end
  endtask

  function automatic logic [15:0] grant_for(logic [15:0] want);
    logic [31:0] g;
    g = {16'd0, want};
    if (link != LS_OPEN || want == 0) return 16'd0;
    if (pkt_mode) return (g < PKT_BODY_MAX) ? want : PKT_BODY_MAX;
    if (conn_tx_win < g) g = conn_tx_win;
    if (up_tx_win < g) g = up_tx_win;
    if (g > ChunkLimit) g = ChunkLimit;
    conn_tx_win -= g;
    up_tx_win -= g;
    return g[15:0];
  endfunction

  task automatic predict(in_t it);
    step_cnt = 0;
    if (link == LS_FAIL) emit(K_ERROR, 0, 0, 0, 0);
    else if (it.cmd) emit(K_GRANT, 0, 0, 0, grant_for(it.want_len));
    else take_byte(it.rx_byte);
    if (step_cnt > 0) step_res[step_cnt - 1].last = 1'b1;
    for (int i = 0; i < step_cnt; i++) results_q.push_back(step_res[i]);
  endtask

  task automatic compare(res_t got);
    res_t exp_r;
    if (results_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: unexpected result kind=%0d data=%02h", $time, got.kind,
                 got.data_byte);
      return;
    end
    exp_r = results_q.pop_front();
    if (got.kind != exp_r.kind || got.data_byte != exp_r.data_byte ||
        got.ping_data != exp_r.ping_data || got.update_stream != exp_r.update_stream ||
        got.grant_len != exp_r.grant_len || got.last != exp_r.last) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: mismatch exp kind=%0d data=%02h ping=%016h strm=%0d grant=%0d last=%0b",
                 $time, exp_r.kind, exp_r.data_byte, exp_r.ping_data, exp_r.update_stream,
                 exp_r.grant_len, exp_r.last,
                 "\n          got kind=%0d data=%02h ping=%016h strm=%0d grant=%0d last=%0b",
                 got.kind, got.data_byte, got.ping_data, got.update_stream,
                 got.grant_len, got.last);
    end
  endtask

  initial begin
    mismatches = 0;
    results_due = 0;
  end

  always @(posedge clk) begin
    if (rst) begin
      down_id = 31'd1;
      up_id = 31'd1;
      pkt_mode = 1'b0;
      hdr_pos = '0;
      frm_len = '0;
      frm_type = '0;
      frm_flags = '0;
      frm_sid = '0;
      pay_pos = '0;
      pad_len = '0;
      shift_reg = '0;
      link = LS_BOOT;
      conn_tx_win = 32'd65535;
      up_tx_win = 32'd65535;
      conn_rx_win = 32'd65535;
      down_rx_win = 32'd65535;
      peer_done = 1'b0;
      results_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_DOWN_ID: down_id = cfg_data;
          REG_UP_ID:   up_id = cfg_data;
          REG_PKT:     pkt_mode = cfg_data[0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) compare(out_data);
      if (in_valid && !in_stall) predict(in_data);
    end
    results_due = results_q.size();
  end

endmodule

// ===== tb/tb_http2_frame_rx_flow_control_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_http2_frame_rx_flow_control_unit
// Feeds the unit HTTP/2 frames, some of them malformed, with random content, write
// requests and register changes under random gaps and output stalls; the
// checker beside the unit predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_http2_frame_rx_flow_control_unit;
  import h2fc_pkg::*;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  in_t         in_data;
  logic        out_valid;
  logic        out_stall;
  res_t        out_data;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [30:0] cfg_data;

  int          mismatches;
  int          results_due;

  // items waiting to be offered on the input channel
  in_t         offer_q[$];
  int          offered;
  logic [7:0]  body[$];
  logic [30:0] cur_down, cur_up;
  bit          hold_req;

  http2_frame_rx_flow_control_unit uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  h2fc_checker chk (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .mismatches(mismatches), .results_due(results_due)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Sender: offer queued items in bursts; hold valid and payload while stalled.
  initial begin
    int burst_left;
    int gap_left;
    burst_left = 0;
    gap_left = 0;
    in_valid = 1'b0;
    in_data = '0;
    forever begin
      @(posedge clk);
      if (in_valid && !in_stall) begin
        void'(offer_q.pop_front());
        if (burst_left > 0) burst_left--;
      end
      if (in_valid && in_stall) begin
        // hold the stalled transaction
      end else if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (offer_q.size() > 0 && !rst) begin
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 40);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
        if (gap_left > 0) begin
          in_valid <= 1'b0;
        end else begin
          in_valid <= 1'b1;
          in_data <= offer_q[0];
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: stall with a duty that changes every stretch; one long hold-off.
  initial begin
    int pct;
    int stretch;
    int hold_cnt;
    bit hold_done;
    pct = 0;
    stretch = 0;
    hold_cnt = 0;
    hold_done = 1'b0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        hold_cnt = 400;
      end
      if (stretch == 0) begin
        stretch = $urandom_range(30, 250);
        case ($urandom_range(0, 3))
          0: pct = 0;
          1: pct = 20;
          2: pct = 50;
          default: pct = 70;
        endcase
      end
      stretch--;
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(0, 99) < pct);
      end
    end
  end

  initial begin
    #20ms;
    $display("[http2_frame_rx_flow_control_unit] ERROR");
    $finish;
  end

  task automatic rx(logic [7:0] b);
    in_t it;
    it.cmd = 1'b0;
    it.rx_byte = b;
    it.want_len = 16'($urandom());
    offer_q.push_back(it);
    offered++;
  endtask

  task automatic write_req(logic [15:0] want);
    in_t it;
    it.cmd = 1'b1;
    it.rx_byte = 8'($urandom());
    it.want_len = want;
    offer_q.push_back(it);
    offered++;
  endtask

  // Queue a frame whose payload is the current body.
  task automatic frame(logic [7:0] ftype, logic [7:0] flags, logic [30:0] sid);
    logic [23:0] len;
    len = 24'(body.size());
    rx(len[23:16]); rx(len[15:8]); rx(len[7:0]);
    rx(ftype); rx(flags);
    rx({1'($urandom()), sid[30:24]}); rx(sid[23:16]); rx(sid[15:8]); rx(sid[7:0]);
    foreach (body[i]) rx(body[i]);
    body.delete();
  endtask

  task automatic add_rand(int n);
    repeat (n) body.push_back(8'($urandom()));
  endtask

  task automatic add_word(logic [31:0] w);
    body.push_back(w[31:24]); body.push_back(w[23:16]);
    body.push_back(w[15:8]); body.push_back(w[7:0]);
  endtask

  task automatic add_setting(logic [15:0] id, logic [31:0] val);
    body.push_back(id[15:8]); body.push_back(id[7:0]);
    add_word(val);
  endtask

  // Padded or plain DATA body: pad length byte, data, padding.
  task automatic data_body(bit padded, int n, int pad);
    if (padded) body.push_back(8'(pad));
    add_rand(n);
    if (padded) add_rand(pad);
  endtask

  task automatic wait_idle();
    while (offer_q.size() != 0 || in_valid || results_due != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [30:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_regs(logic [30:0] dn, logic [30:0] up, bit pkt);
    wait_idle();
    cur_down = dn;
    cur_up = up;
    write_reg(REG_DOWN_ID, dn);
    write_reg(REG_UP_ID, up);
    write_reg(REG_PKT, {30'd0, pkt});
  endtask

  function automatic logic [30:0] pick_sid();
    case ($urandom_range(0, 5))
      0: return 31'd0;
      1: return cur_up;
      2: return 31'($urandom());
      default: return cur_down;
    endcase
  endfunction

  function automatic logic [31:0] pick_val();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return $urandom_range(0, 300);
      default: return $urandom_range(1000, 70000);
    endcase
  endfunction

  task automatic random_frame();
    int r;
    int n;
    logic [7:0] fl;
    r = $urandom_range(0, 99);
    fl = 8'($urandom());
    if (r < 30) begin
      // DATA, mostly on the download stream, sometimes badly padded
      n = $urandom_range(0, 12);
      if (fl[3] && $urandom_range(0, 7) == 0) begin
        body.push_back(8'($urandom_range(n + 1, 255)));
        add_rand(n);
      end else begin
        data_body(fl[3], n, $urandom_range(0, 5));
      end
      frame(FT_DATA, fl, ($urandom_range(0, 4) == 0) ? pick_sid() : cur_down);
    end else if (r < 45) begin
      repeat ($urandom_range(1, 3))
        write_req(($urandom_range(0, 3) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 2000)));
    end else if (r < 55) begin
      repeat ($urandom_range(0, 3))
        add_setting(($urandom_range(0, 1) == 0) ? SET_ID_WINDOW : 16'($urandom()), pick_val());
      if ($urandom_range(0, 3) == 0) add_rand($urandom_range(1, 5));
      frame(FT_SETTINGS, ($urandom_range(0, 3) == 0) ? fl : (fl & ~FL_ACK), pick_sid());
    end else if (r < 65) begin
      if ($urandom_range(0, 5) == 0) add_rand($urandom_range(0, 6));
      else add_word(pick_val());
      frame(FT_WINUPD, fl, pick_sid());
    end else if (r < 73) begin
      add_rand(($urandom_range(0, 4) == 0) ? $urandom_range(0, 10) : 8);
      frame(FT_PING, ($urandom_range(0, 3) == 0) ? fl : (fl & ~FL_ACK), pick_sid());
    end else if (r < 80) begin
      add_rand($urandom_range(0, 6));
      frame(FT_HEADERS, fl, pick_sid());
    end else if (r < 88) begin
      // skip types the unit does not act on
      add_rand($urandom_range(0, 8));
      case ($urandom_range(0, 2))
        0: frame(8'd2, fl, pick_sid());
        1: frame(8'd5, fl, pick_sid());
        default: frame(8'($urandom_range(9, 255)), fl, pick_sid());
      endcase
    end else begin
      data_body(fl[3], $urandom_range(0, 10), $urandom_range(0, 3));
      frame(FT_DATA, fl, 31'($urandom()) | 31'd2);
    end
  endtask

  initial begin
    int base;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    hold_req = 1'b0;
    offered = 0;
    cur_down = 31'd1;
    cur_up = 31'd1;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    set_regs(31'd1, 31'd3, 1'b0);

    // link still booting: every request gets nothing
    write_req(16'd100);
    write_req(16'd0);
    // open the link and shrink the send windows
    add_setting(SET_ID_WINDOW, 32'd1000);
    add_rand(3);
    frame(FT_SETTINGS, 8'h00, 31'd0);
    write_req(16'hffff);
    write_req(16'd1);
    add_word(32'd500);
    frame(FT_WINUPD, 8'h00, 31'd0);
    add_word(32'hffff_ffff);
    frame(FT_WINUPD, 8'h00, 31'd3);
    write_req(16'hffff);
    add_rand(8);
    frame(FT_PING, 8'h00, 31'd0);
    add_rand(8);
    frame(FT_PING, FL_ACK, 31'd0);
    add_rand(7);
    frame(FT_PING, 8'h00, 31'd0);
    frame(FT_HEADERS, FL_END, 31'd1);
    data_body(1'b1, 4, 2);
    frame(FT_DATA, FL_PADDED | FL_END, 31'd1);
    frame(FT_DATA, FL_PADDED, 31'd1);
    body.push_back(8'd9);
    add_rand(3);
    frame(FT_DATA, FL_PADDED, 31'd1);
    data_body(1'b0, 3, 0);
    frame(FT_DATA, 8'hff, 31'd1);
    frame(FT_SETTINGS, FL_ACK, 31'd0);

    // packet mode ignores the windows
    set_regs(31'd1, 31'd3, 1'b1);
    write_req(16'hffff);
    write_req(16'd32768);
    write_req(16'd32767);
    write_req(16'd0);

    // send window wrap, extreme stream ids
    set_regs(31'h7fff_ffff, 31'd0, 1'b0);
    add_setting(SET_ID_WINDOW, 32'hffff_ffff);
    frame(FT_SETTINGS, 8'h00, 31'd0);
    add_word(32'h7fff_ffff);
    frame(FT_WINUPD, 8'h00, 31'd0);
    write_req(16'hffff);
    data_body(1'b0, 5, 0);
    frame(FT_DATA, FL_END, 31'h7fff_ffff);
    set_regs(31'd0, 31'h7fff_ffff, 1'b0);
    data_body(1'b1, 3, 1);
    frame(FT_DATA, FL_PADDED, 31'd0);
    add_word(32'd77);
    frame(FT_WINUPD, 8'h00, 31'h7fff_ffff);
    write_req(16'd70);

    // random traffic
    set_regs(31'd1, 31'd3, 1'b0);
    base = offered;
    while (offered - base < 200) begin
      random_frame();
      if (!hold_req && offered - base > 40 && offered - base < 80) begin
        // long receiver hold-off with the sender still offering
        hold_req = 1'b1;
        data_body(1'b0, 60, 0);
        frame(FT_DATA, 8'h00, cur_down);
      end
      case ($urandom_range(0, 39))
        0: wait_idle();
        1: set_regs(($urandom_range(0, 1) == 0) ? 31'd1 : 31'($urandom_range(0, 7)),
                    ($urandom_range(0, 1) == 0) ? 31'd3 : 31'($urandom_range(0, 7)),
                    1'($urandom_range(0, 1)));
        default: ;
      endcase
      while (offer_q.size() > 64) @(posedge clk);
    end

    // fatal frame, then everything answers with an error
    wait_idle();
    add_rand(4);
    frame(FT_RST, 8'h00, 31'd1);
    repeat (6) begin
      if ($urandom_range(0, 1) == 0) write_req(16'($urandom()));
      else rx(8'($urandom()));
    end

    while (offer_q.size() != 0 || in_valid || results_due != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0 && results_due == 0) begin
      $display("[http2_frame_rx_flow_control_unit] OK");
    end else begin
      $display("[http2_frame_rx_flow_control_unit] ERROR");
    end
    $finish;
  end

endmodule
